### hdl/power_collision_state_tracker_defines.svh
// assertion macros for the power collision state tracker
// used by the core; no other dependencies
`ifndef POWER_COLLISION_STATE_TRACKER_DEFINES_SVH
`define POWER_COLLISION_STATE_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define PCT_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PCT_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define PCT_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

### hdl/pct_pkg.sv
// shared types, codes and helpers for the power collision state tracker
// no dependencies
`default_nettype none

package pct_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam logic [1:0] MODE_HIGH  = 2'd0;
  localparam logic [1:0] MODE_TRANS = 2'd1;
  localparam logic [1:0] MODE_LOW   = 2'd2;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_COLLISION = 2'd1;
  localparam logic [1:0] EV_CLEAR     = 2'd2;

  localparam logic [1:0] CFG_THRESHOLD_A = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_B = 2'd1;
  localparam logic [1:0] CFG_RUN_LENGTH  = 2'd2;

  localparam logic [15:0] RUN_LENGTH_RST = 16'd64;

  typedef logic [COUNT_WIDTH-1:0] run_cnt_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] track_state;
    logic [7:0] collisions;
  } result_t;

  typedef struct packed {
    logic     hit;
    run_cnt_t cnt;
  } tick_t;

  // saturating run count step, hit when the run reaches run_length
  function automatic tick_t run_tick(input run_cnt_t cnt, input logic [15:0] run_len);
    tick_t t;
    t.cnt = (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : run_cnt_t'(cnt + 1'b1);
    t.hit = (32'(t.cnt) == 32'(run_len));
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/pct_core.sv
// tracking state and per-sample update for the power collision state tracker
// depends on pct_pkg and power_collision_state_tracker_defines.svh
`default_nettype none
`include "power_collision_state_tracker_defines.svh"

module pct_core
  import pct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic signed [15:0] power_db,
  input  wire logic               restart,
  input  wire logic signed [15:0] threshold_a,
  input  wire logic signed [15:0] threshold_b,
  input  wire logic [15:0]        run_length,
  output result_t                 res
);

  logic [1:0] mode_r, mode_nxt;
  run_cnt_t   level_run_r, level_run_nxt;
  run_cnt_t   coll_run_r, coll_run_nxt;
  logic [7:0] count_r, count_nxt;

  logic signed [15:0] thr_hi, thr_lo;
  logic [1:0]         ev;
  tick_t              t_lvl, t_col;

  assign thr_hi = (threshold_a > threshold_b) ? threshold_a : threshold_b;
  assign thr_lo = (threshold_a > threshold_b) ? threshold_b : threshold_a;

  always_comb begin
    mode_nxt      = mode_r;
    level_run_nxt = level_run_r;
    coll_run_nxt  = coll_run_r;
    count_nxt     = count_r;
    ev            = EV_NONE;

    if (restart && mode_r != MODE_HIGH) begin
      mode_nxt      = MODE_HIGH;
      level_run_nxt = '0;
      coll_run_nxt  = '0;
      count_nxt     = '0;
    end

    t_lvl = run_tick(level_run_nxt, run_length);
    t_col = run_tick(coll_run_nxt, run_length);

    case (mode_nxt)
      MODE_TRANS: begin
        if (power_db > thr_hi) begin
          if (t_col.hit) begin
            coll_run_nxt = '0;
            if (count_nxt != 8'hFF) count_nxt = count_nxt + 8'd1;
          end else begin
            coll_run_nxt = t_col.cnt;
          end
        end else begin
          coll_run_nxt = '0;
        end
        if (power_db < thr_lo) begin
          if (t_lvl.hit) begin
            mode_nxt      = MODE_LOW;
            level_run_nxt = '0;
          end else begin
            level_run_nxt = t_lvl.cnt;
          end
        end else begin
          level_run_nxt = '0;
        end
      end
      MODE_LOW: begin
        if (power_db > thr_lo) begin
          if (t_lvl.hit) begin
            level_run_nxt = '0;
            if (count_nxt != 8'd0) count_nxt = count_nxt - 8'd1;
            if (count_nxt == 8'd0) begin
              mode_nxt     = MODE_HIGH;
              coll_run_nxt = '0;
              ev           = EV_CLEAR;
            end
          end else begin
            level_run_nxt = t_lvl.cnt;
          end
        end else begin
          level_run_nxt = '0;
        end
      end
      default: begin
        mode_nxt = MODE_HIGH;
        if (power_db > thr_hi) begin
          if (t_lvl.hit) begin
            mode_nxt      = MODE_TRANS;
            level_run_nxt = '0;
            coll_run_nxt  = '0;
            count_nxt     = 8'd1;
            ev            = EV_COLLISION;
          end else begin
            level_run_nxt = t_lvl.cnt;
          end
        end else begin
          level_run_nxt = '0;
        end
      end
    endcase
  end

  assign res.event_res   = ev;
  assign res.track_state = mode_nxt;
  assign res.collisions  = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_HIGH;
      level_run_r <= '0;
      coll_run_r  <= '0;
      count_r     <= '0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      level_run_r <= level_run_nxt;
      coll_run_r  <= coll_run_nxt;
      count_r     <= count_nxt;
    end
  end

  `PCT_ASSERT_IMPL(a_high_no_count, clk, rst_n, mode_r == MODE_HIGH, count_r == 8'd0 && coll_run_r == '0, "count or collision run left over in HIGH")
  `PCT_ASSERT_IMPL(a_busy_has_count, clk, rst_n, mode_r != MODE_HIGH, count_r != 8'd0, "TRANS or LOW with zero collisions")
  `PCT_ASSERT_IMPL(a_coll_event, clk, rst_n, step && ev == EV_COLLISION, mode_nxt == MODE_TRANS && count_nxt == 8'd1 && (mode_r == MODE_HIGH || restart), "collision event with wrong state")
  `PCT_ASSERT_IMPL(a_clear_event, clk, rst_n, step && ev == EV_CLEAR, $past(1'b1) && mode_r == MODE_LOW && !restart && mode_nxt == MODE_HIGH, "clear event outside LOW")

endmodule

`default_nettype wire

### hdl/power_collision_state_tracker.sv
// top level of the power collision state tracker: stream ports, config regs,
// input and result registers; depends on pct_pkg and pct_core
//
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tdata power_db, tuser restart
// out_      out  out_tvalid/out_tready  tdata event_res, track_state, collisions
// cfg_      in   cfg_wr_en              cfg_index, cfg_wdata
//
// one sample per cycle unless the output stalls; input register then result register
// the update of mode, run counters and collision count is a registered feedback loop
// synchronous active-low reset returns to HIGH with counters cleared
// a stalled output holds; the input register still takes a sample while
// the result waits, then stalls
`default_nettype none

module power_collision_state_tracker
  import pct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] power_db
  input  wire logic        in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [1:0] event_res, [3:2] track_state, [11:4] collisions
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic signed [15:0] thr_a_r, thr_b_r;
  logic [15:0]        run_len_r;

  logic               s1_v_r;
  logic signed [15:0] s1_power_r;
  logic               s1_restart_r;
  logic               out_v_r;
  result_t            out_res_r;
  result_t            res;
  logic               s2_free, step;

  assign s2_free   = !out_v_r || out_tready;
  assign step      = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_a_r   <= '0;
      thr_b_r   <= '0;
      run_len_r <= RUN_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD_A: thr_a_r   <= cfg_wdata;
        CFG_THRESHOLD_B: thr_b_r   <= cfg_wdata;
        CFG_RUN_LENGTH:  run_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_power_r   <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  pct_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .power_db    (s1_power_r),
    .restart     (s1_restart_r),
    .threshold_a (thr_a_r),
    .threshold_b (thr_b_r),
    .run_length  (run_len_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_res_r.collisions, out_res_r.track_state, out_res_r.event_res};

endmodule

`default_nettype wire
